FILE: hdl/mse_pkg.sv
`default_nettype none

package mse_pkg;

  // Number of insertion cells, and so the most values one run can keep.
  localparam int unsigned LIST_DEPTH = 32;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Commands from the controller to the cell row.
  typedef struct packed {
    logic insert;
    logic set_ovf;
    logic shift;
    logic clear_ovf;
  } mse_cmd_t;

  // Status from the cell row to the controller.
  typedef struct packed {
    logic full;
    logic last_one;
  } mse_status_t;

endpackage

`default_nettype wire

FILE: hdl/merge_sort_engine.sv
// Channel   Handshake                  Payload
// input     in_valid / in_stall        value, is_last
// output    out_valid / out_stall      sorted_value, last_out, overflow
//
// Each input transaction drops its value into a row of
// LIST_DEPTH compare-and-shift cells that keeps the run in ascending order.
// After the transaction marked last, the row shifts out one result per cycle
// while out_stall is low. Input is stalled while results drain; a stalled
// result holds in cell zero. Reset empties the row at once.
`default_nettype none

module merge_sort_engine
  import mse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] value,
  input  wire logic               is_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      sorted_value,
  output logic                    last_out,
  output logic                    overflow
);

  mse_cmd_t    cmd;
  mse_status_t status;

  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mse_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

FILE: hdl/mse_datapath.sv
`default_nettype none

module mse_datapath
  import mse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] value,
  input  wire mse_cmd_t           cmd,
  output mse_status_t             status,
  output logic signed [31:0]      sorted_value,
  output logic                    last_out,
  output logic                    overflow
);

  // Row of insertion cells. Valid cells are packed at the low end and kept
  // in ascending order, so cell zero always holds the smallest value.
  logic signed [31:0] slot      [LIST_DEPTH];
  logic signed [31:0] slot_next [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] vld;
  logic [LIST_DEPTH-1:0] vld_next;
  logic [LIST_DEPTH-1:0] gt;
  logic ovf;
  logic ovf_next;

  // A cell makes room when it is empty or holds a larger value than the new one.
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      gt[i] = !vld[i] || (slot[i] > value);
    end
  end

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      slot_next[i] = slot[i];
    end
    vld_next = vld;
    if (cmd.insert) begin
      if (gt[0]) begin
        slot_next[0] = value;
      end
      vld_next[0] = 1'b1;
      for (int i = 1; i < LIST_DEPTH; i++) begin
        if (gt[i]) begin
          slot_next[i] = gt[i-1] ? slot[i-1] : value;
        end
        vld_next[i] = vld[i] | vld[i-1];
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        slot_next[i] = slot[i+1];
        vld_next[i]  = vld[i+1];
      end
      vld_next[LIST_DEPTH-1] = 1'b0;
    end
  end

  always_comb begin
    ovf_next = ovf;
    if (cmd.set_ovf) begin
      ovf_next = 1'b1;
    end else if (cmd.clear_ovf) begin
      ovf_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      ovf <= 1'b0;
    end else begin
      vld <= vld_next;
      ovf <= ovf_next;
    end
  end

  assign status.full     = vld[LIST_DEPTH-1];
  assign status.last_one = vld[0] && !vld[1];

  assign sorted_value = slot[0];
  assign last_out     = status.last_one;
  assign overflow     = ovf;

endmodule

`default_nettype wire

FILE: hdl/mse_ctrl.sv
`default_nettype none

module mse_ctrl
  import mse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        is_last,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire mse_status_t status,
  output mse_cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   in_acc;
  logic   out_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    in_acc        = 1'b0;
    out_acc       = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        in_acc   = in_valid;
        // A value that finds the row full is dropped and flags the run.
        cmd.insert  = in_acc && !status.full;
        cmd.set_ovf = in_acc && status.full;
        if (in_acc && is_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid     = 1'b1;
        out_acc       = !out_stall;
        cmd.shift     = out_acc;
        cmd.clear_ovf = out_acc && status.last_one;
        if (out_acc && status.last_one) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire
